### hdl/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg
// Shared widths, defaults and link type of the streaming FIR filter.
// ----------------------------------------------------------------------------
package fss_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned MaxTaps     = 8;
  localparam int unsigned TapCountDef = 8;
  localparam int unsigned CfgIdxW     = $clog2(MaxTaps);

  typedef logic [DataW-1:0] data_t;

  // word moving from one cell to the next
  typedef struct packed {
    logic  valid;
    data_t sum;
  } link_t;

endpackage

### hdl/fss_delay_line.sv
// ----------------------------------------------------------------------------
// fss_delay_line
// Sample history at the filter input; gives the window that the accepted
// word sees, newest sample first, with an optional clear before it enters.
// ----------------------------------------------------------------------------
module fss_delay_line #(
  parameter int unsigned TAP_COUNT = fss_pkg::TapCountDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic          clear_i,
  input  fss_pkg::data_t sample_i,
  output fss_pkg::data_t win_o [TAP_COUNT]
);

  fss_pkg::data_t tap_q [TAP_COUNT];
  fss_pkg::data_t tap_d [TAP_COUNT];

  always_comb begin
    tap_d[0] = sample_i;
    for (int unsigned i = 1; i < TAP_COUNT; i++) begin
      tap_d[i] = clear_i ? '0 : tap_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < TAP_COUNT; i++) begin
        tap_q[i] <= '0;
      end
    end else if (accept_i) begin
      tap_q <= tap_d;
    end
  end

  assign win_o = tap_d;

endmodule

### hdl/fss_cell.sv
// ----------------------------------------------------------------------------
// fss_cell
// One tap of the filter chain: multiplies its coefficient with its sample
// of the carried window and hands the running sum to the next cell.
// ----------------------------------------------------------------------------
module fss_cell #(
  parameter int unsigned TAP_COUNT = fss_pkg::TapCountDef,
  parameter int unsigned CELL_IDX  = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fss_pkg::data_t coef_i,
  input  fss_pkg::link_t link_i,
  input  fss_pkg::data_t win_i [TAP_COUNT],
  input  logic           nxt_ready_i,
  output logic           ready_o,
  output fss_pkg::link_t link_o,
  output fss_pkg::data_t win_o [TAP_COUNT]
);

  logic           valid_q;
  fss_pkg::data_t sum_q;
  fss_pkg::data_t prod_q;
  fss_pkg::data_t prod_d;
  fss_pkg::data_t win_q [TAP_COUNT];

  // low word of the product is all that survives the wrap
  assign prod_d  = coef_i * win_i[CELL_IDX];
  assign ready_o = !valid_q || nxt_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= link_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && link_i.valid) begin
      sum_q  <= link_i.sum;
      prod_q <= prod_d;
      win_q  <= win_i;
    end
  end

  assign link_o.valid = valid_q;
  assign link_o.sum   = sum_q + prod_q;
  assign win_o        = win_q;

endmodule

### hdl/fir_filter_stream_core.sv
// ----------------------------------------------------------------------------
// fir_filter_stream_core
// Direct-form FIR filter over a stream of signed 32-bit samples.
// ----------------------------------------------------------------------------
// Input channel: sample_i and clear_first_i, taken when in_valid_i is high
// and in_stall_o is low. clear_first_i zeroes the sample history before
// the new sample enters. Each accepted word gives exactly one filtered_o
// word on the output channel, in order, taken when out_valid_o is high and
// out_stall_i is low. Coefficients are written through cfg_we_i, cfg_idx_i
// and cfg_data_i; the user must do so only while the filter is idle, which
// the block does not enforce. Writes at or above TAP_COUNT are dropped.
// An accepted word passes through the chain of TAP_COUNT cells, one multiply
// and one add per cell, and then the output register before out_valid_o.
// Throughput: one word per cycle while in_stall_o is low; every cell advances
// on its own when the next one is empty or moving, so empty slots close up.
// Reset clears the history, the coefficients and all valid flags.
// While the receiver stalls, the output word holds and the chain keeps
// filling; in_stall_o rises only when every cell and the output are full.
// ----------------------------------------------------------------------------
module fir_filter_stream_core #(
  parameter int unsigned TAP_COUNT = fss_pkg::TapCountDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fss_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [fss_pkg::DataW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [fss_pkg::DataW-1:0] sample_i,
  input  logic                        clear_first_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [fss_pkg::DataW-1:0] filtered_o
);

  fss_pkg::data_t coef_q [TAP_COUNT];
  fss_pkg::link_t link   [TAP_COUNT+1];
  fss_pkg::data_t win    [TAP_COUNT+1][TAP_COUNT];
  logic           rdy    [TAP_COUNT+1];
  logic           accept;
  logic           out_valid_q;
  fss_pkg::data_t filtered_q;

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < TAP_COUNT; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      for (int unsigned i = 0; i < TAP_COUNT; i++) begin
        if (cfg_idx_i == fss_pkg::CfgIdxW'(i)) begin
          coef_q[i] <= cfg_data_i;
        end
      end
    end
  end

  assign in_stall_o = !rdy[0];
  assign accept     = in_valid_i && rdy[0];

  fss_delay_line #(
    .TAP_COUNT (TAP_COUNT)
  ) u_delay_line (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .clear_i  (clear_first_i),
    .sample_i (fss_pkg::data_t'(sample_i)),
    .win_o    (win[0])
  );

  assign link[0].valid = in_valid_i;
  assign link[0].sum   = '0;

  for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
    fss_cell #(
      .TAP_COUNT (TAP_COUNT),
      .CELL_IDX  (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .coef_i      (coef_q[k]),
      .link_i      (link[k]),
      .win_i       (win[k]),
      .nxt_ready_i (rdy[k+1]),
      .ready_o     (rdy[k]),
      .link_o      (link[k+1]),
      .win_o       (win[k+1])
    );
  end

  // output register
  assign rdy[TAP_COUNT] = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy[TAP_COUNT]) begin
      out_valid_q <= link[TAP_COUNT].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[TAP_COUNT] && link[TAP_COUNT].valid) begin
      filtered_q <= link[TAP_COUNT].sum;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = $signed(filtered_q);

  // assertions
  logic [TAP_COUNT-1:0] cell_full;

  always_comb begin
    for (int unsigned i = 0; i < TAP_COUNT; i++) begin
      cell_full[i] = link[i+1].valid;
    end
  end

  a_accept_fills_cell0 : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    accept |=> cell_full[0]
  ) else $error("accepted word did not reach the first cell");

  a_stall_only_when_full : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&cell_full) && out_valid_q && out_stall_i)
  ) else $error("input stalled while the chain has room");

  a_out_drains : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !link[TAP_COUNT].valid) |=> !out_valid_q
  ) else $error("output word repeated after it was taken");

endmodule
